// ===== design/bilrgba_pkg.sv =====
// Shared constants for the bilinear RGBA blend pipeline.
// No dependencies; used by every stage module and the top level.
package bilrgba_pkg;

  // One color channel is one byte; a pixel holds four of them (ARGB).
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;

endpackage

// ===== design/bilrgba_hstage.sv =====
// Pipeline stage 1: horizontal blend of the lower and upper pixel rows.
// Depends on bilrgba_pkg.
module bilrgba_hstage #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bilrgba_pkg::PIX_W-1:0]           lower_left,
  input  logic [bilrgba_pkg::PIX_W-1:0]           lower_right,
  input  logic [bilrgba_pkg::PIX_W-1:0]           upper_left,
  input  logic [bilrgba_pkg::PIX_W-1:0]           upper_right,
  input  logic [FRAC_BITS-1:0]                    frac_x,
  input  logic [FRAC_BITS-1:0]                    frac_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [bilrgba_pkg::NUM_CHAN-1:0][bilrgba_pkg::CHAN_W+FRAC_BITS-1:0] lo_row,
  output logic [bilrgba_pkg::NUM_CHAN-1:0][bilrgba_pkg::CHAN_W+FRAC_BITS-1:0] hi_row,
  output logic [FRAC_BITS-1:0]                    frac_y_q
);

  localparam int RW = bilrgba_pkg::CHAN_W + FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]                           w_left;
  logic [bilrgba_pkg::NUM_CHAN-1:0][RW:0]       lo_sum;
  logic [bilrgba_pkg::NUM_CHAN-1:0][RW:0]       hi_sum;
  logic                                         valid;

  assign w_left = ONE - {1'b0, frac_x};

  // Each row sum is at most 255 * one, so it fits in CHAN_W + FRAC_BITS bits.
  always_comb begin
    for (int c = 0; c < bilrgba_pkg::NUM_CHAN; c++) begin
      lo_sum[c] = (RW+1)'(w_left)
                  * (RW+1)'(lower_left[c*bilrgba_pkg::CHAN_W +: bilrgba_pkg::CHAN_W])
                + (RW+1)'(frac_x)
                  * (RW+1)'(lower_right[c*bilrgba_pkg::CHAN_W +: bilrgba_pkg::CHAN_W]);
      hi_sum[c] = (RW+1)'(w_left)
                  * (RW+1)'(upper_left[c*bilrgba_pkg::CHAN_W +: bilrgba_pkg::CHAN_W])
                + (RW+1)'(frac_x)
                  * (RW+1)'(upper_right[c*bilrgba_pkg::CHAN_W +: bilrgba_pkg::CHAN_W]);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int c = 0; c < bilrgba_pkg::NUM_CHAN; c++) begin
        lo_row[c] <= lo_sum[c][RW-1:0];
        hi_row[c] <= hi_sum[c][RW-1:0];
      end
      frac_y_q <= frac_y;
    end
  end

endmodule

// ===== design/bilrgba_vstage.sv =====
// Pipeline stage 2: vertical blend of the two row results, full precision.
// Depends on bilrgba_pkg.
module bilrgba_vstage #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bilrgba_pkg::NUM_CHAN-1:0][bilrgba_pkg::CHAN_W+FRAC_BITS-1:0] lo_row,
  input  logic [bilrgba_pkg::NUM_CHAN-1:0][bilrgba_pkg::CHAN_W+FRAC_BITS-1:0] hi_row,
  input  logic [FRAC_BITS-1:0]                    frac_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [bilrgba_pkg::NUM_CHAN-1:0][bilrgba_pkg::CHAN_W+2*FRAC_BITS-1:0] blend
);

  localparam int SW = bilrgba_pkg::CHAN_W + 2*FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]                           w_lower;
  logic [bilrgba_pkg::NUM_CHAN-1:0][SW:0]       v_sum;
  logic                                         valid;

  assign w_lower = ONE - {1'b0, frac_y};

  always_comb begin
    for (int c = 0; c < bilrgba_pkg::NUM_CHAN; c++) begin
      v_sum[c] = (SW+1)'(w_lower) * (SW+1)'(lo_row[c])
               + (SW+1)'(frac_y) * (SW+1)'(hi_row[c]);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int c = 0; c < bilrgba_pkg::NUM_CHAN; c++) begin
        blend[c] <= v_sum[c][SW-1:0];
      end
    end
  end

endmodule

// ===== design/bilrgba_round.sv =====
// Pipeline stage 3: half-up rounding to 8 bits per channel; output register.
// Depends on bilrgba_pkg.
module bilrgba_round #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bilrgba_pkg::NUM_CHAN-1:0][bilrgba_pkg::CHAN_W+2*FRAC_BITS-1:0] blend,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [bilrgba_pkg::PIX_W-1:0]           pixel
);

  localparam int SW = bilrgba_pkg::CHAN_W + 2*FRAC_BITS;
  localparam logic [SW:0] HALF = (SW+1)'(1) << (2*FRAC_BITS - 1);

  logic [bilrgba_pkg::NUM_CHAN-1:0][SW:0]       rnd;
  logic                                         valid;

  // The sum stays below 255.5 * one * one, so the rounded value never exceeds 255.
  always_comb begin
    for (int c = 0; c < bilrgba_pkg::NUM_CHAN; c++) begin
      rnd[c] = {1'b0, blend[c]} + HALF;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int c = 0; c < bilrgba_pkg::NUM_CHAN; c++) begin
        pixel[c*bilrgba_pkg::CHAN_W +: bilrgba_pkg::CHAN_W] <= rnd[c][SW-1:2*FRAC_BITS];
      end
    end
  end

endmodule

// ===== design/bilinear_rgba_blend.sv =====
// Bilinear ARGB8888 blend. Throughput is one request per cycle while the result side takes
// results; a three-stage register pipeline (row multiply-add, column multiply-add, rounding
// add) carries each request, and stalls propagate back through ready.
// Reset (rst, synchronous, active high) clears the stage valid bits; data registers
// are not reset. Depends on bilrgba_pkg, bilrgba_hstage, bilrgba_vstage, bilrgba_round.
module bilinear_rgba_blend #(
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  // Request channel.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, from bit 0 up: lower_left[31:0], lower_right[31:0], upper_left[31:0],
  // upper_right[31:0], frac_x[7:0], frac_y[7:0].
  input  logic [143:0] s_axis_tdata,
  // Result channel.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, from bit 0 up: blended_pixel[31:0].
  output logic [31:0]  m_axis_tdata
);

  localparam int RW = bilrgba_pkg::CHAN_W + FRAC_BITS;
  localparam int SW = bilrgba_pkg::CHAN_W + 2*FRAC_BITS;

  // Unpacked request fields.
  logic [bilrgba_pkg::PIX_W-1:0] lower_left;
  logic [bilrgba_pkg::PIX_W-1:0] lower_right;
  logic [bilrgba_pkg::PIX_W-1:0] upper_left;
  logic [bilrgba_pkg::PIX_W-1:0] upper_right;
  logic [7:0]                    frac_x;
  logic [7:0]                    frac_y;
  logic [FRAC_BITS+7:0]          frac_x_ext;
  logic [FRAC_BITS+7:0]          frac_y_ext;

  // Stage interconnect.
  logic                                          h_valid;
  logic                                          v_ready;
  logic [bilrgba_pkg::NUM_CHAN-1:0][RW-1:0]      lo_row;
  logic [bilrgba_pkg::NUM_CHAN-1:0][RW-1:0]      hi_row;
  logic [FRAC_BITS-1:0]                          frac_y_q;
  logic                                          v_valid;
  logic                                          r_ready;
  logic [bilrgba_pkg::NUM_CHAN-1:0][SW-1:0]      blend;

  assign lower_left  = s_axis_tdata[31:0];
  assign lower_right = s_axis_tdata[63:32];
  assign upper_left  = s_axis_tdata[95:64];
  assign upper_right = s_axis_tdata[127:96];
  assign frac_x      = s_axis_tdata[135:128];
  assign frac_y      = s_axis_tdata[143:136];

  // The fractions carry FRAC_BITS fractional bits. With fewer than eight, the
  // upper field bits are an integer part and are dropped; with more, the field is
  // zero-extended, so the largest fraction is 255 / 2^FRAC_BITS.
  assign frac_x_ext = {{FRAC_BITS{1'b0}}, frac_x};
  assign frac_y_ext = {{FRAC_BITS{1'b0}}, frac_y};

  // Stage 1 forms both row blends for all four channels in parallel.
  bilrgba_hstage #(
    .FRAC_BITS(FRAC_BITS)
  ) u_hstage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .lower_left (lower_left),
    .lower_right(lower_right),
    .upper_left (upper_left),
    .upper_right(upper_right),
    .frac_x     (frac_x_ext[FRAC_BITS-1:0]),
    .frac_y     (frac_y_ext[FRAC_BITS-1:0]),
    .out_valid  (h_valid),
    .out_ready  (v_ready),
    .lo_row     (lo_row),
    .hi_row     (hi_row),
    .frac_y_q   (frac_y_q)
  );

  // Stage 2 blends the rows vertically and keeps all 2*FRAC_BITS fraction bits.
  bilrgba_vstage #(
    .FRAC_BITS(FRAC_BITS)
  ) u_vstage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (h_valid),
    .in_ready (v_ready),
    .lo_row   (lo_row),
    .hi_row   (hi_row),
    .frac_y   (frac_y_q),
    .out_valid(v_valid),
    .out_ready(r_ready),
    .blend    (blend)
  );

  // Stage 3 rounds once, half up, and is the output register; a waiting result
  // blocks new requests once the earlier stages are full, through ready.
  bilrgba_round #(
    .FRAC_BITS(FRAC_BITS)
  ) u_round (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_valid),
    .in_ready (r_ready),
    .blend    (blend),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .pixel    (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // A ready sink means no stage holds, so the block must take requests.
  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("request refused while the result side is ready");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // With the sink ready throughout, an accepted request reaches the output without a stall.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing three cycles after request");

  // Only a completely full pipeline may refuse a request.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (h_valid && v_valid && m_axis_tvalid && !m_axis_tready))
    else $error("request refused while a stage is free");
`endif

endmodule
